// ===== rtl/bwg_pkg.sv =====
// Package of the bilinear weight generator: widths, configuration layout,
// queue entry types and the state encoding of the arithmetic back end.
// No dependencies; every other file of the block refers to it by scoped names.
package bwg_pkg;

  localparam int COORD_W          = 32;
  localparam int OFS_W            = COORD_W + 1;
  localparam int STEP_W           = 31;
  localparam int CNT_W            = 13;
  localparam int TOL_W            = 16;
  localparam int MAX_COLUMNS      = 4096;
  localparam int MAX_ROWS         = 4096;
  localparam int IDX_W            = $clog2(MAX_COLUMNS);
  localparam int SPAN_W           = IDX_W + STEP_W;
  localparam int COORD_FRAC_BITS  = 16;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WGT_W            = WEIGHT_FRAC_BITS + 1;
  localparam int GIDX_W           = 24;
  localparam int NARROW_Q         = IDX_W;
  localparam int WIDE_Q           = WGT_W;
  localparam int DIVD_W           = WIDE_Q + STEP_W;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(1) << WEIGHT_FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_STEP_X     = 3'd2,
    REG_STEP_Y     = 3'd3,
    REG_COLUMNS    = 3'd4,
    REG_ROWS       = 3'd5,
    REG_ROWS_DESC  = 3'd6,
    REG_TOLERANCE  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [STEP_W-1:0]         step_x;
    logic [STEP_W-1:0]         step_y;
    logic [CNT_W-1:0]          columns;
    logic [CNT_W-1:0]          rows;
    logic                      rows_descending;
    logic [TOL_W-1:0]          tolerance;
  } cfg_t;

  // Offsets of one point from line 0 of each axis, in the direction of
  // increasing line index.
  typedef struct packed {
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
  } item_t;

  typedef struct packed {
    logic [GIDX_W-1:0] grid_index;
    logic [WGT_W-1:0]  weight;
    logic              outside_domain;
    logic              last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINE,
    ST_LINE_DIV,
    ST_CELL,
    ST_CELL_DIV,
    ST_ALPHA,
    ST_INDEX,
    ST_EMIT
  } back_state_e;

endpackage

// ===== rtl/bilinear_weight_generator.sv =====
// Top level of the bilinear weight generator: configuration registers,
// front end, arithmetic back end and port-level checks.
// Depends on bwg_pkg, bwg_front and bwg_back.
//
//   Channel   Direction  Handshake            Payload
//   ------    ---------  -------------------  ----------------------------------
//   point     in         push_i / full_o      point_x_i, point_y_i, halo_point_i
//   node      out        pop_i / empty_o      grid_index_o, weight_o,
//                                             outside_domain_o, last_o
//   config    in         cfg_valid_i/ready_o  cfg_index_i, cfg_data_i
//
// The time a point spends in the back end is set by the shared divider,
// which produces one quotient bit per cycle and then hands over its result.
// Per axis the back end runs the line test, the cell search and, for a
// spanning axis, the weight; it then forms the base index and emits the
// nodes, holding while the result queue is full. Halo points are dropped in
// the front end at one per cycle. Reset clears all control state and loads
// the configuration reset values. The two-entry point queue lets new points
// arrive while the back end works, and the two-entry result queue lets the
// back end keep going while the consumer stalls.
module bilinear_weight_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic signed [bwg_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [bwg_pkg::COORD_W-1:0]  point_y_i,
  input  logic                                halo_point_i,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic [bwg_pkg::GIDX_W-1:0]          grid_index_o,
  output logic [bwg_pkg::WGT_W-1:0]           weight_o,
  output logic                                outside_domain_o,
  output logic                                last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bwg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bwg_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  bwg_pkg::cfg_t  cfg_q;
  bwg_pkg::item_t item;
  bwg_pkg::res_t  res;
  logic           item_valid, item_pop;

  // Registers are always writable; the user only writes while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x        <= '0;
      cfg_q.origin_y        <= '0;
      cfg_q.step_x          <= bwg_pkg::STEP_W'(1) << bwg_pkg::COORD_FRAC_BITS;
      cfg_q.step_y          <= bwg_pkg::STEP_W'(1) << bwg_pkg::COORD_FRAC_BITS;
      cfg_q.columns         <= bwg_pkg::CNT_W'(bwg_pkg::MAX_COLUMNS);
      cfg_q.rows            <= bwg_pkg::CNT_W'(bwg_pkg::MAX_ROWS);
      cfg_q.rows_descending <= 1'b0;
      cfg_q.tolerance       <= bwg_pkg::TOL_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bwg_pkg::cfg_reg_e'(cfg_index_i))
        bwg_pkg::REG_ORIGIN_X:  cfg_q.origin_x <= $signed(cfg_data_i);
        bwg_pkg::REG_ORIGIN_Y:  cfg_q.origin_y <= $signed(cfg_data_i);
        bwg_pkg::REG_STEP_X:    cfg_q.step_x <= cfg_data_i[bwg_pkg::STEP_W-1:0];
        bwg_pkg::REG_STEP_Y:    cfg_q.step_y <= cfg_data_i[bwg_pkg::STEP_W-1:0];
        bwg_pkg::REG_COLUMNS:   cfg_q.columns <= cfg_data_i[bwg_pkg::CNT_W-1:0];
        bwg_pkg::REG_ROWS:      cfg_q.rows <= cfg_data_i[bwg_pkg::CNT_W-1:0];
        bwg_pkg::REG_ROWS_DESC: cfg_q.rows_descending <= cfg_data_i[0];
        bwg_pkg::REG_TOLERANCE: cfg_q.tolerance <= cfg_data_i[bwg_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // The front end turns each point into axis offsets and queues it.
  bwg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .halo_point_i (halo_point_i),
    .full_o       (full_o),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // The back end places the point and emits its weighted nodes.
  bwg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .res_o        (res)
  );

  assign grid_index_o     = res.grid_index;
  assign weight_o         = res.weight;
  assign outside_domain_o = res.outside_domain;
  assign last_o           = res.last;

  // The back end only takes a point that the front end holds.
  a_pop_from_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("back end took a point from an empty queue");

  // A nearest-node fallback is always a single node of full weight.
  a_outside_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && outside_domain_o) |-> (last_o && weight_o == bwg_pkg::WEIGHT_ONE))
    else $error("outside-domain node is not a single full-weight node");

  // No weight exceeds one.
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (weight_o <= bwg_pkg::WEIGHT_ONE))
    else $error("weight above one");

endmodule

// ===== rtl/bwg_front.sv =====
// Front end of the bilinear weight generator: takes points, drops halo
// points and queues the axis offsets of the others in a two-entry queue.
// Depends on bwg_pkg.
module bwg_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bwg_pkg::cfg_t                      cfg_i,
  input  logic                               push_i,
  input  logic signed [bwg_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [bwg_pkg::COORD_W-1:0] point_y_i,
  input  logic                               halo_point_i,
  output logic                               full_o,
  output logic                               item_valid_o,
  output bwg_pkg::item_t                     item_o,
  input  logic                               item_pop_i
);

  bwg_pkg::item_t entry_q [2];
  bwg_pkg::item_t new_item;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           wr_en;

  always_comb begin
    new_item.ox = bwg_pkg::OFS_W'(point_x_i) - bwg_pkg::OFS_W'(cfg_i.origin_x);
    if (cfg_i.rows_descending) begin
      new_item.oy = bwg_pkg::OFS_W'(cfg_i.origin_y) - bwg_pkg::OFS_W'(point_y_i);
    end else begin
      new_item.oy = bwg_pkg::OFS_W'(point_y_i) - bwg_pkg::OFS_W'(cfg_i.origin_y);
    end
  end

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];
  // A halo point is taken but never queued.
  assign wr_en        = push_i && !full_o && !halo_point_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, item_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ===== rtl/bwg_div.sv =====
// Restoring divider of the bilinear weight generator, one quotient bit per
// cycle, 12 quotient bits in narrow mode and 17 in wide mode.
// Depends on bwg_pkg.
module bwg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          wide_i,
  input  logic [bwg_pkg::DIVD_W-1:0]    dividend_i,
  input  logic [bwg_pkg::STEP_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [bwg_pkg::WIDE_Q-1:0]    quotient_o,
  output logic [bwg_pkg::STEP_W-1:0]    remainder_o
);

  logic                         busy_q, done_q;
  logic [4:0]                   cnt_q;
  logic [bwg_pkg::STEP_W-1:0]   rem_q;
  logic [bwg_pkg::WIDE_Q-1:0]   sh_q, quo_q;
  logic [bwg_pkg::STEP_W:0]     trial, diff;
  logic                         ge;

  // The caller guarantees dividend < divisor * 2^quotient_bits, so the
  // upper part loaded into the remainder is already below the divisor.
  assign trial = {rem_q, sh_q[bwg_pkg::WIDE_Q-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= wide_i ? 5'(bwg_pkg::WIDE_Q) : 5'(bwg_pkg::NARROW_Q);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= '0;
      if (wide_i) begin
        rem_q <= dividend_i[bwg_pkg::WIDE_Q+bwg_pkg::STEP_W-1:bwg_pkg::WIDE_Q];
        sh_q  <= dividend_i[bwg_pkg::WIDE_Q-1:0];
      end else begin
        rem_q <= dividend_i[bwg_pkg::NARROW_Q+bwg_pkg::STEP_W-1:bwg_pkg::NARROW_Q];
        sh_q  <= {dividend_i[bwg_pkg::NARROW_Q-1:0],
                  {(bwg_pkg::WIDE_Q-bwg_pkg::NARROW_Q){1'b0}}};
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff[bwg_pkg::STEP_W-1:0] : trial[bwg_pkg::STEP_W-1:0];
      sh_q  <= sh_q << 1;
      quo_q <= {quo_q[bwg_pkg::WIDE_Q-2:0], ge};
    end
  end

endmodule

// ===== rtl/bwg_back.sv =====
// Back end of the bilinear weight generator: places each queued point on
// both axes with the shared divider, then writes its weighted nodes into a
// two-entry result queue. Depends on bwg_pkg and bwg_div.
module bwg_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bwg_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  bwg_pkg::item_t item_i,
  output logic           item_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bwg_pkg::res_t  res_o
);

  localparam int IW = bwg_pkg::IDX_W;
  localparam int SW = bwg_pkg::STEP_W;
  localparam int LW = bwg_pkg::SPAN_W;
  localparam int WW = bwg_pkg::WGT_W;
  localparam int CW = bwg_pkg::CNT_W;
  localparam int XW = LW + 2;

  function automatic logic [CW-1:0] clamp_count(input logic [CW-1:0] v,
                                                input logic [CW-1:0] hi);
    logic [CW-1:0] r;
    if (v < CW'(2)) begin
      r = CW'(2);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Derived grid geometry, refreshed every cycle from the registers.
  logic [SW-1:0] sx_q, sy_q, sx_c, sy_c;
  logic [IW-1:0] nm1x_q, nm1y_q, nm1x_c, nm1y_c;
  logic [CW-1:0] nrow_q, ncol_c, nrow_c;
  logic [LW-1:0] lx_q, ly_q;

  always_comb begin
    sx_c   = (cfg_i.step_x == '0) ? SW'(1) : cfg_i.step_x;
    sy_c   = (cfg_i.step_y == '0) ? SW'(1) : cfg_i.step_y;
    ncol_c = clamp_count(cfg_i.columns, CW'(bwg_pkg::MAX_COLUMNS));
    nrow_c = clamp_count(cfg_i.rows, CW'(bwg_pkg::MAX_ROWS));
    nm1x_c = IW'(ncol_c - CW'(1));
    nm1y_c = IW'(nrow_c - CW'(1));
  end

  always_ff @(posedge clk_i) begin
    sx_q   <= sx_c;
    sy_q   <= sy_c;
    nm1x_q <= nm1x_c;
    nm1y_q <= nm1y_c;
    nrow_q <= nrow_c;
    lx_q   <= LW'(nm1x_c) * LW'(sx_c);
    ly_q   <= LW'(nm1y_c) * LW'(sy_c);
  end

  // Sequencer state.
  bwg_pkg::back_state_e state_q, state_d;
  logic                 axis_q;
  logic [1:0]           k_q;
  bwg_pkg::item_t       pt_q;

  // Per-axis placement results.
  logic          placed_q [2];
  logic          span_q   [2];
  logic [IW-1:0] idx_q    [2];
  logic [IW-1:0] near_q   [2];
  logic [WW-1:0] alpha_q  [2];

  // Node emission state.
  logic [bwg_pkg::GIDX_W-1:0] base_q;
  logic                       xspan_q, yspan_q, outside_q;
  logic [WW-1:0]              ax_q, ay_q;

  // Divider.
  logic                        div_start, div_wide, div_done;
  logic [bwg_pkg::DIVD_W-1:0]  div_dvd;
  logic [bwg_pkg::WIDE_Q-1:0]  div_quo;
  logic [SW-1:0]               div_rem;

  // Operands of the current axis.
  logic signed [bwg_pkg::OFS_W-1:0] o_c;
  logic [SW-1:0]                    s_c;
  logic [LW-1:0]                    l_c;
  logic [IW-1:0]                    nm1_c;
  logic signed [bwg_pkg::OFS_W+1:0] num_c;
  logic signed [XW-1:0]             num_w, l_w, o_w, omt_w, dl_w, abs_o, abs_dl;
  logic                             num_ge_l, last_hit, in_cell, near_lo;
  logic                             line_hit, cell_next;

  always_comb begin
    o_c    = axis_q ? pt_q.oy : pt_q.ox;
    s_c    = axis_q ? sy_q : sx_q;
    l_c    = axis_q ? ly_q : lx_q;
    nm1_c  = axis_q ? nm1y_q : nm1x_q;
    num_c  = (bwg_pkg::OFS_W+2)'(o_c)
           + $signed({2'b00, {(bwg_pkg::OFS_W-bwg_pkg::TOL_W){1'b0}}, cfg_i.tolerance})
           - (bwg_pkg::OFS_W+2)'(1);
    num_w  = XW'(num_c);
    l_w    = $signed({2'b00, l_c});
    o_w    = XW'(o_c);
    omt_w  = o_w - $signed({{(XW-bwg_pkg::TOL_W){1'b0}}, cfg_i.tolerance});
    dl_w   = o_w - l_w;
    abs_o  = o_w[XW-1] ? -o_w : o_w;
    abs_dl = dl_w[XW-1] ? -dl_w : dl_w;
    num_ge_l = num_w >= l_w;
    // Highest line clamped to the last one: it qualifies when it lies
    // above the lower edge of the tolerance band.
    last_hit = l_w > omt_w;
    in_cell  = !o_c[bwg_pkg::OFS_W-1] && (o_w < l_w);
    near_lo  = abs_o < abs_dl;
    // num = k*s + rem, so k*s > o - t reduces to rem < 2t - 1.
    line_hit  = ({1'b0, div_rem} + (SW+1)'(1))
              < {{(SW-bwg_pkg::TOL_W){1'b0}}, cfg_i.tolerance, 1'b0};
    cell_next = ({1'b0, s_c} - {1'b0, div_rem}) < {1'b0, div_rem};
  end

  // Result queue.
  bwg_pkg::res_t fifo_q [2];
  logic          fwr_q, frd_q;
  logic [1:0]    fcnt_q;
  logic          res_full, emit_we;
  bwg_pkg::res_t emit_res;

  assign res_full = (fcnt_q == 2'd2);
  assign empty_o  = (fcnt_q == 2'd0);
  assign res_o    = fifo_q[frd_q];

  // Node generation: node code c has bit 0 for column i+1 and bit 1 for
  // row j+1; a non-spanning axis is skipped in the sequence.
  logic [1:0]            c_c, klast_c;
  logic [WW-1:0]         fx_c, fy_c;
  logic [2*WW-1:0]       prod_c;
  logic                  last_c;

  always_comb begin
    c_c     = (yspan_q && !xspan_q) ? {k_q[0], 1'b0} : k_q;
    klast_c = {xspan_q && yspan_q, xspan_q || yspan_q};
    last_c  = (k_q == klast_c);
    fx_c    = c_c[0] ? ax_q : bwg_pkg::WEIGHT_ONE - ax_q;
    fy_c    = c_c[1] ? ay_q : bwg_pkg::WEIGHT_ONE - ay_q;
    prod_c  = (2*WW)'(fx_c) * (2*WW)'(fy_c)
            + (2*WW)'(bwg_pkg::WEIGHT_ONE >> 1);
    emit_res.weight         = prod_c[bwg_pkg::WEIGHT_FRAC_BITS+WW-1:bwg_pkg::WEIGHT_FRAC_BITS];
    emit_res.grid_index     = base_q
                            + (c_c[0] ? bwg_pkg::GIDX_W'(nrow_q) : '0)
                            + (c_c[1] ? bwg_pkg::GIDX_W'(1) : '0);
    emit_res.outside_domain = outside_q;
    emit_res.last           = last_c;
  end

  // Controls from the sequencer.
  logic          load, ax_we, ax_placed, ax_span, alpha_we, axis_done, idx_we;
  logic [IW-1:0] ax_idx, ax_near;

  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    load       = 1'b0;
    div_start  = 1'b0;
    div_wide   = 1'b0;
    div_dvd    = '0;
    ax_we      = 1'b0;
    ax_placed  = 1'b0;
    ax_span    = 1'b0;
    ax_idx     = '0;
    ax_near    = '0;
    alpha_we   = 1'b0;
    axis_done  = 1'b0;
    idx_we     = 1'b0;
    emit_we    = 1'b0;
    case (state_q)
      bwg_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          load       = 1'b1;
          state_d    = bwg_pkg::ST_LINE;
        end
      end
      bwg_pkg::ST_LINE: begin
        if (num_c[bwg_pkg::OFS_W+1]) begin
          state_d = bwg_pkg::ST_CELL;
        end else if (num_ge_l) begin
          if (last_hit) begin
            ax_we     = 1'b1;
            ax_placed = 1'b1;
            ax_idx    = nm1_c;
            ax_near   = nm1_c;
            axis_done = 1'b1;
          end else begin
            state_d = bwg_pkg::ST_CELL;
          end
        end else begin
          div_start = 1'b1;
          div_dvd   = bwg_pkg::DIVD_W'(num_c[bwg_pkg::OFS_W:0]);
          state_d   = bwg_pkg::ST_LINE_DIV;
        end
      end
      bwg_pkg::ST_LINE_DIV: begin
        if (div_done) begin
          if (line_hit) begin
            ax_we     = 1'b1;
            ax_placed = 1'b1;
            ax_idx    = div_quo[IW-1:0];
            ax_near   = div_quo[IW-1:0];
            axis_done = 1'b1;
          end else begin
            state_d = bwg_pkg::ST_CELL;
          end
        end
      end
      bwg_pkg::ST_CELL: begin
        if (in_cell) begin
          div_start = 1'b1;
          div_dvd   = bwg_pkg::DIVD_W'(o_c[bwg_pkg::OFS_W-2:0]);
          state_d   = bwg_pkg::ST_CELL_DIV;
        end else begin
          ax_we     = 1'b1;
          ax_near   = near_lo ? '0 : nm1_c;
          axis_done = 1'b1;
        end
      end
      bwg_pkg::ST_CELL_DIV: begin
        if (div_done) begin
          ax_we     = 1'b1;
          ax_placed = 1'b1;
          ax_span   = 1'b1;
          ax_idx    = div_quo[IW-1:0];
          ax_near   = cell_next ? div_quo[IW-1:0] + IW'(1) : div_quo[IW-1:0];
          div_start = 1'b1;
          div_wide  = 1'b1;
          div_dvd   = {1'b0, div_rem, {bwg_pkg::WEIGHT_FRAC_BITS{1'b0}}}
                    + bwg_pkg::DIVD_W'(s_c[SW-1:1]);
          state_d   = bwg_pkg::ST_ALPHA;
        end
      end
      bwg_pkg::ST_ALPHA: begin
        if (div_done) begin
          alpha_we  = 1'b1;
          axis_done = 1'b1;
        end
      end
      bwg_pkg::ST_INDEX: begin
        idx_we  = 1'b1;
        state_d = bwg_pkg::ST_EMIT;
      end
      bwg_pkg::ST_EMIT: begin
        if (!res_full) begin
          emit_we = 1'b1;
          if (last_c) begin
            state_d = bwg_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = bwg_pkg::ST_IDLE;
    endcase
    if (axis_done) begin
      state_d = axis_q ? bwg_pkg::ST_INDEX : bwg_pkg::ST_LINE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bwg_pkg::ST_IDLE;
      axis_q  <= 1'b0;
      k_q     <= 2'd0;
      fwr_q   <= 1'b0;
      frd_q   <= 1'b0;
      fcnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      if (load) begin
        axis_q <= 1'b0;
      end else if (axis_done) begin
        axis_q <= !axis_q;
      end
      if (idx_we) begin
        k_q <= 2'd0;
      end else if (emit_we) begin
        k_q <= k_q + 2'd1;
      end
      if (emit_we) begin
        fwr_q <= !fwr_q;
      end
      if (pop_i && !empty_o) begin
        frd_q <= !frd_q;
      end
      fcnt_q <= fcnt_q + {1'b0, emit_we} - {1'b0, pop_i && !empty_o};
    end
  end

  logic          outside_c;
  logic [IW-1:0] i_c, j_c;

  always_comb begin
    outside_c = !(placed_q[0] && placed_q[1]);
    i_c       = outside_c ? near_q[0] : idx_q[0];
    j_c       = outside_c ? near_q[1] : idx_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pt_q <= item_i;
    end
    if (ax_we) begin
      placed_q[axis_q] <= ax_placed;
      span_q[axis_q]   <= ax_span;
      idx_q[axis_q]    <= ax_idx;
      near_q[axis_q]   <= ax_near;
    end
    if (alpha_we) begin
      alpha_q[axis_q] <= div_quo;
    end
    if (idx_we) begin
      base_q    <= bwg_pkg::GIDX_W'((IW+CW)'(i_c) * (IW+CW)'(nrow_q) + (IW+CW)'(j_c));
      outside_q <= outside_c;
      xspan_q   <= !outside_c && span_q[0];
      yspan_q   <= !outside_c && span_q[1];
      ax_q      <= (!outside_c && span_q[0]) ? alpha_q[0] : '0;
      ay_q      <= (!outside_c && span_q[1]) ? alpha_q[1] : '0;
    end
    if (emit_we) begin
      fifo_q[fwr_q] <= emit_res;
    end
  end

  bwg_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .wide_i      (div_wide),
    .dividend_i  (div_dvd),
    .divisor_i   (s_c),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

endmodule
